FILE: rtl/real_time_timer_with_alarm_defines.svh
// Assertion macros used by the real-time timer top level.
`ifndef REAL_TIME_TIMER_WITH_ALARM_DEFINES_SVH
`define REAL_TIME_TIMER_WITH_ALARM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTTA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer check failed");

// The consequent must hold in the cycle after the antecedent.
`define RTTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer check failed");

`endif

FILE: rtl/rtta_pkg.sv
// Types and constants of the real-time timer with alarm.
`timescale 1ns / 1ps

package rtta_pkg;

    typedef enum logic [1:0] {
        KIND_SLOW  = 2'd0,
        KIND_HZ    = 2'd1,
        KIND_READ  = 2'd2,
        KIND_WRITE = 2'd3
    } t_kind;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_ALARM  = 3'd1;
    localparam logic [2:0] REG_VALUE  = 3'd2;
    localparam logic [2:0] REG_STATUS = 3'd3;
    localparam logic [2:0] REG_MODULO = 3'd4;
    localparam logic [2:0] REG_TSTAMP = 3'd5;

    localparam int MODE_W     = 25;
    localparam int PRESCALE_W = 17;

    // Mode word bit positions.
    localparam int MR_ALMIEN_BIT = 16;
    localparam int MR_INCIEN_BIT = 17;
    localparam int MR_RST_BIT    = 18;
    localparam int MR_DIS_BIT    = 20;
    localparam int MR_INC2EN_BIT = 21;
    localparam int MR_1HZ_BIT    = 24;

    localparam logic [MODE_W-1:0] MR_WMASK = 25'h133FFFF;
    localparam logic [MODE_W-1:0] MODE_RESET = 25'h0008000;
    localparam logic [31:0] ALARM_RESET = 32'hFFFFFFFF;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 17'h08000;
    localparam logic [PRESCALE_W-1:0] PRESCALE_FULL = 17'h10000;

    // Status flag bit positions.
    localparam int ST_ALM_BIT  = 0;
    localparam int ST_INC_BIT  = 1;
    localparam int ST_INC2_BIT = 2;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
        logic        write_protected;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_level;
    } t_out_item;

    // State seen by the top level for checking.
    typedef struct packed {
        logic [31:0] count;
        logic [2:0]  status;
        logic        disabled;
    } t_rtta_view;

endpackage

FILE: rtl/rtta_core.sv
// Timer register file and single-pass next-state logic for one item.
`timescale 1ns / 1ps

module rtta_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  rtta_pkg::t_in_item    i_item,
    output rtta_pkg::t_out_item   o_res,
    output rtta_pkg::t_rtta_view  o_view
);

    logic [rtta_pkg::MODE_W-1:0]     r_mode, n_mode;
    logic [31:0]                     r_alarm, n_alarm;
    logic [31:0]                     r_count, n_count;
    logic [2:0]                      r_status, n_status;
    logic [2:0]                      r_sel, n_sel;
    logic [31:0]                     r_tstamp, n_tstamp;
    logic [rtta_pkg::PRESCALE_W-1:0] r_prescale, n_prescale;

    logic [31:0]                     w_cnt1;
    logic                            w_alm_hit;
    logic [12:0]                     w_span_mask;
    logic                            w_cap;
    logic                            w_bump;
    logic [rtta_pkg::PRESCALE_W-1:0] w_load_cur;
    logic [rtta_pkg::PRESCALE_W-1:0] w_load_new;
    logic [31:0]                     w_rd;

    // Increment path evaluated in parallel; applied only when a bump happens.
    assign w_cnt1      = r_count + 32'd1;
    assign w_alm_hit   = (w_cnt1 == r_alarm);
    assign w_span_mask = 13'((13'd1 << ({1'b0, r_sel} + 4'd5)) - 13'd1);
    assign w_cap       = (r_sel != 3'd0) && ((w_cnt1[12:0] & w_span_mask) == 13'd0);

    // A prescaler field of zero stands for a full 65536-tick period.
    assign w_load_cur = (r_mode[15:0] == 16'd0) ? rtta_pkg::PRESCALE_FULL
                                                : {1'b0, r_mode[15:0]};
    assign w_load_new = (i_item.write_data[15:0] == 16'd0) ? rtta_pkg::PRESCALE_FULL
                                                           : {1'b0, i_item.write_data[15:0]};

    always_comb begin
        n_mode     = r_mode;
        n_alarm    = r_alarm;
        n_count    = r_count;
        n_status   = r_status;
        n_sel      = r_sel;
        n_tstamp   = r_tstamp;
        n_prescale = r_prescale;
        w_bump     = 1'b0;
        w_rd       = 32'd0;

        unique case (i_item.kind)
            rtta_pkg::KIND_SLOW: begin
                if (!r_mode[rtta_pkg::MR_DIS_BIT]) begin
                    if (r_prescale <= 17'd1) begin
                        n_status[rtta_pkg::ST_INC_BIT] = 1'b1;
                        w_bump     = !r_mode[rtta_pkg::MR_1HZ_BIT];
                        n_prescale = w_load_cur;
                    end else begin
                        n_prescale = r_prescale - 17'd1;
                    end
                end
            end
            rtta_pkg::KIND_HZ: begin
                w_bump = !r_mode[rtta_pkg::MR_DIS_BIT] && r_mode[rtta_pkg::MR_1HZ_BIT];
            end
            rtta_pkg::KIND_READ: begin
                unique case (i_item.reg_index)
                    rtta_pkg::REG_MODE:   w_rd = {7'd0, r_mode};
                    rtta_pkg::REG_ALARM:  w_rd = r_alarm;
                    rtta_pkg::REG_VALUE:  w_rd = r_count;
                    rtta_pkg::REG_STATUS: begin
                        // Reading status clears the flags and the overflow mark.
                        w_rd         = {29'd0, r_status};
                        n_status     = 3'd0;
                        n_tstamp[31] = 1'b0;
                    end
                    rtta_pkg::REG_MODULO: w_rd = {29'd0, r_sel};
                    rtta_pkg::REG_TSTAMP: w_rd = r_tstamp;
                    default:              w_rd = 32'd0;
                endcase
            end
            rtta_pkg::KIND_WRITE: begin
                if (!i_item.write_protected) begin
                    unique case (i_item.reg_index)
                        rtta_pkg::REG_MODE: begin
                            n_mode = i_item.write_data[rtta_pkg::MODE_W-1:0]
                                     & rtta_pkg::MR_WMASK;
                            if (i_item.write_data[rtta_pkg::MR_RST_BIT]) begin
                                n_count    = 32'd0;
                                n_prescale = w_load_new;
                            end
                        end
                        rtta_pkg::REG_ALARM:  n_alarm = i_item.write_data;
                        rtta_pkg::REG_MODULO: n_sel   = i_item.write_data[2:0];
                        default: begin
                            n_alarm = r_alarm;
                        end
                    endcase
                end
            end
        endcase

        if (w_bump) begin
            n_count = w_cnt1;
            if (w_alm_hit) begin
                n_status[rtta_pkg::ST_ALM_BIT] = 1'b1;
            end
            if (w_cap) begin
                n_tstamp = {r_status[rtta_pkg::ST_INC2_BIT], w_cnt1[30:0]};
                n_status[rtta_pkg::ST_INC2_BIT] = 1'b1;
            end
        end
    end

    assign o_res.read_data = w_rd;
    assign o_res.irq_level =
        (n_status[rtta_pkg::ST_ALM_BIT]  && n_mode[rtta_pkg::MR_ALMIEN_BIT]) ||
        (n_status[rtta_pkg::ST_INC_BIT]  && n_mode[rtta_pkg::MR_INCIEN_BIT]) ||
        (n_status[rtta_pkg::ST_INC2_BIT] && n_mode[rtta_pkg::MR_INC2EN_BIT]);

    assign o_view.count    = r_count;
    assign o_view.status   = r_status;
    assign o_view.disabled = r_mode[rtta_pkg::MR_DIS_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= rtta_pkg::MODE_RESET;
            r_alarm    <= rtta_pkg::ALARM_RESET;
            r_count    <= 32'd0;
            r_status   <= 3'd0;
            r_sel      <= 3'd0;
            r_tstamp   <= 32'd0;
            r_prescale <= rtta_pkg::PRESCALE_RESET;
        end else if (i_en) begin
            r_mode     <= n_mode;
            r_alarm    <= n_alarm;
            r_count    <= n_count;
            r_status   <= n_status;
            r_sel      <= n_sel;
            r_tstamp   <= n_tstamp;
            r_prescale <= n_prescale;
        end
    end

endmodule

FILE: rtl/real_time_timer_with_alarm.sv
// The input register feeds the timer state update and result logic, which the
// output register holds until taken. Throughput: one item per cycle while
// results are taken.
// Reset (synchronous, active low) empties both registers and returns the
// timer to its defaults: prescaler 32768, alarm all ones, counter zero.
`timescale 1ns / 1ps
`include "real_time_timer_with_alarm_defines.svh"

module real_time_timer_with_alarm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rtta_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rtta_pkg::t_out_item  o_item
);

    rtta_pkg::t_in_item   r_in;
    logic                 r_in_valid;
    rtta_pkg::t_out_item  r_out;
    logic                 r_out_valid;
    logic                 w_adv;
    rtta_pkg::t_out_item  w_res;
    rtta_pkg::t_rtta_view w_view;

    // The held item is processed when the output register is free or being emptied.
    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    rtta_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_item  (r_in),
        .o_res   (w_res),
        .o_view  (w_view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    `RTTA_ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, w_adv, r_out_valid)
    `RTTA_ASSERT_SAME(a_no_overrun, i_clk, i_rst_n, i_valid && o_ready,
        !r_in_valid || w_adv)
    `RTTA_ASSERT_NEXT(a_status_read_clears, i_clk, i_rst_n,
        w_adv && (r_in.kind == rtta_pkg::KIND_READ) && (r_in.reg_index == rtta_pkg::REG_STATUS),
        w_view.status == 3'd0)
    `RTTA_ASSERT_NEXT(a_disabled_holds_count, i_clk, i_rst_n,
        w_adv && w_view.disabled &&
        ((r_in.kind == rtta_pkg::KIND_SLOW) || (r_in.kind == rtta_pkg::KIND_HZ)),
        $stable(w_view.count))

endmodule

FILE: dv/real_time_timer_with_alarm_tb.sv
// Self-checking testbench of the real-time timer with alarm, with a predictor of its own.
`timescale 1ns / 1ps

module real_time_timer_with_alarm_tb;
    import rtta_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int BURST_TICKS = 140;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    real_time_timer_with_alarm dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted timer state.
    logic [MODE_W-1:0]     tm_mode;
    logic [31:0]           tm_alarm;
    logic [31:0]           tm_count;
    logic [2:0]            tm_status;
    logic [2:0]            tm_sel;
    logic [31:0]           tm_stamp;
    logic [PRESCALE_W-1:0] tm_presc;

    t_out_item timer_expect_q[$];

    int n_items = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_captures = 0;
    int n_alarm_hits = 0;
    int n_rollovers = 0;
    int stall_cycles = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int phase = 0;

    function automatic void timer_reset();
        tm_mode   = MODE_RESET;
        tm_alarm  = ALARM_RESET;
        tm_count  = '0;
        tm_status = '0;
        tm_sel    = '0;
        tm_stamp  = '0;
        tm_presc  = PRESCALE_RESET;
    endfunction

    function automatic logic [PRESCALE_W-1:0] reload_count();
        return (tm_mode[15:0] == 16'd0) ? PRESCALE_FULL : {1'b0, tm_mode[15:0]};
    endfunction

    function automatic void count_bump();
        logic [31:0] span_mask;
        tm_count = tm_count + 32'd1;
        if (tm_count == tm_alarm) begin
            tm_status[ST_ALM_BIT] = 1'b1;
            n_alarm_hits++;
        end
        if (tm_sel != 3'd0) begin
            span_mask = (32'd1 << (int'(tm_sel) + 5)) - 32'd1;
            if ((tm_count & span_mask) == 32'd0) begin
                // The overflow mark records a capture that nobody has acknowledged yet.
                tm_stamp = {tm_status[ST_INC2_BIT], tm_count[30:0]};
                tm_status[ST_INC2_BIT] = 1'b1;
                n_captures++;
            end
        end
    endfunction

    function automatic t_out_item timer_apply(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.kind)
            KIND_SLOW: begin
                if (!tm_mode[MR_DIS_BIT]) begin
                    if (tm_presc <= 17'd1) begin
                        tm_status[ST_INC_BIT] = 1'b1;
                        n_rollovers++;
                        if (!tm_mode[MR_1HZ_BIT]) count_bump();
                        tm_presc = reload_count();
                    end else begin
                        tm_presc = tm_presc - 17'd1;
                    end
                end
            end
            KIND_HZ: begin
                if (!tm_mode[MR_DIS_BIT] && tm_mode[MR_1HZ_BIT]) count_bump();
            end
            KIND_READ: begin
                case (it.reg_index)
                    REG_MODE:   r.read_data = 32'(tm_mode);
                    REG_ALARM:  r.read_data = tm_alarm;
                    REG_VALUE:  r.read_data = tm_count;
                    REG_STATUS: begin
                        r.read_data = 32'(tm_status);
                        tm_status = '0;
                        tm_stamp[31] = 1'b0;
                    end
                    REG_MODULO: r.read_data = 32'(tm_sel);
                    REG_TSTAMP: r.read_data = tm_stamp;
                    default:    r.read_data = '0;
                endcase
            end
            KIND_WRITE: begin
                if (!it.write_protected) begin
                    case (it.reg_index)
                        REG_MODE: begin
                            tm_mode = it.write_data[MODE_W-1:0] & MR_WMASK;
                            if (it.write_data[MR_RST_BIT]) begin
                                tm_count = '0;
                                tm_presc = reload_count();
                            end
                        end
                        REG_ALARM:  tm_alarm = it.write_data;
                        REG_MODULO: tm_sel = it.write_data[2:0];
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        r.irq_level = (tm_status[ST_ALM_BIT] && tm_mode[MR_ALMIEN_BIT]) ||
                      (tm_status[ST_INC_BIT] && tm_mode[MR_INCIEN_BIT]) ||
                      (tm_status[ST_INC2_BIT] && tm_mode[MR_INC2EN_BIT]);
        return r;
    endfunction

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    t_stim_row stim_table[$];

    function automatic void add_row(t_kind k, logic [2:0] idx, logic [31:0] data, bit prot,
                                    bit typed = 1'b0, logic [31:0] rd = '0, bit irq = 1'b0);
        t_stim_row row;
        row.item.kind = k;
        row.item.reg_index = idx;
        row.item.write_data = data;
        row.item.write_protected = prot;
        row.typed = typed;
        row.want.read_data = rd;
        row.want.irq_level = irq;
        stim_table.push_back(row);
    endfunction

    // Offers one item, with random idle cycles first, and records what it should give.
    task automatic send_item(t_in_item it, bit typed, t_out_item want);
        t_out_item pred;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (!o_ready);
        pred = timer_apply(it);
        timer_expect_q.push_back(typed ? want : pred);
        n_items++;
    endtask

    // Result side: checks each item taken and decides when to stall.
    always @(posedge i_clk) begin : result_side
        t_out_item want;
        int hold_left;
        bit hold_done;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (timer_expect_q.size() == 0) begin
                    $display("%0t: result with none expected: read_data=%h irq_level=%b",
                             $time, o_item.read_data, o_item.irq_level);
                    n_errors++;
                end else begin
                    want = timer_expect_q.pop_front();
                    if (o_item.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h, got %h",
                                 $time, want.read_data, o_item.read_data);
                        n_errors++;
                    end
                    if (o_item.irq_level !== want.irq_level) begin
                        $display("%0t: irq_level expected %b, got %b",
                                 $time, want.irq_level, o_item.irq_level);
                        n_errors++;
                    end
                    n_checked++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (phase == 2 && !hold_done) begin
                // One long stall while the sender keeps offering, so the input backs up.
                hold_done = 1'b1;
                hold_left = RX_HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item it;
        logic [31:0] wd;
        int pick;
        int shape;
        int n;

        timer_reset();

        // Register defaults, ignored and protected writes, then the alarm, one-hertz
        // mode and disable paths.
        add_row(KIND_READ, REG_MODE, 32'h0, 1'b0, 1'b1, 32'h0000_8000, 1'b0);
        add_row(KIND_READ, REG_ALARM, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        add_row(KIND_READ, REG_VALUE, 32'h0, 1'b0, 1'b1, 32'h0, 1'b0);
        add_row(KIND_READ, REG_STATUS, 32'h0, 1'b0, 1'b1, 32'h0, 1'b0);
        add_row(KIND_READ, REG_MODULO, 32'h0, 1'b0, 1'b1, 32'h0, 1'b0);
        add_row(KIND_READ, REG_TSTAMP, 32'h0, 1'b0, 1'b1, 32'h0, 1'b0);
        add_row(KIND_READ, 3'd7, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0, 1'b0);
        add_row(KIND_WRITE, REG_MODE, 32'h01FF_FFFF, 1'b1, 1'b1, 32'h0, 1'b0);
        add_row(KIND_READ, REG_MODE, 32'h0, 1'b0, 1'b1, 32'h0000_8000, 1'b0);
        add_row(KIND_WRITE, REG_VALUE, 32'h1234_5678, 1'b0, 1'b1, 32'h0, 1'b0);
        add_row(KIND_WRITE, 3'd6, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0, 1'b0);
        add_row(KIND_WRITE, REG_MODULO, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0, 1'b0);
        add_row(KIND_WRITE, REG_ALARM, 32'h0000_0002, 1'b0, 1'b1, 32'h0, 1'b0);
        add_row(KIND_WRITE, REG_MODE, 32'h0027_0001, 1'b0, 1'b1, 32'h0, 1'b0);
        add_row(KIND_SLOW, 3'd0, 32'h0, 1'b0);
        add_row(KIND_SLOW, 3'd0, 32'h0, 1'b0);
        add_row(KIND_READ, REG_STATUS, 32'h0, 1'b0);
        add_row(KIND_WRITE, REG_MODE, 32'h0114_0000, 1'b0);
        add_row(KIND_HZ, 3'd0, 32'h0, 1'b0);
        add_row(KIND_SLOW, 3'd0, 32'h0, 1'b0);
        add_row(KIND_WRITE, REG_MODE, 32'h0100_0000, 1'b0);
        add_row(KIND_HZ, 3'd0, 32'h0, 1'b0);
        add_row(KIND_READ, REG_VALUE, 32'h0, 1'b0);
        add_row(KIND_WRITE, REG_MODE, 32'h0000_0000, 1'b0);
        add_row(KIND_HZ, 3'd0, 32'h0, 1'b0);
        add_row(KIND_READ, REG_VALUE, 32'h0, 1'b0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 62 : 0;
            rx_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 26 : 0;

            if (phase == 0) begin
                foreach (stim_table[k]) send_item(stim_table[k].item, stim_table[k].typed,
                                                  stim_table[k].want);
            end

            if (phase == 2) begin
                // Enough one-hertz ticks for two boundary captures with no status read
                // between them, so the second one carries the overflow mark.
                it = '0;
                it.kind = KIND_WRITE;
                it.reg_index = REG_MODULO;
                it.write_data = 32'h0000_0001;
                send_item(it, 1'b0, '0);
                it.reg_index = REG_MODE;
                it.write_data = 32'h0124_0003;
                send_item(it, 1'b0, '0);
                for (n = 0; n < BURST_TICKS; n++) begin
                    it.kind = KIND_HZ;
                    it.reg_index = 3'($urandom_range(0, 7));
                    it.write_data = $urandom;
                    it.write_protected = 1'($urandom_range(0, 1));
                    send_item(it, 1'b0, '0);
                end
                it.kind = KIND_READ;
                it.reg_index = REG_TSTAMP;
                send_item(it, 1'b0, '0);
                it.reg_index = REG_STATUS;
                send_item(it, 1'b0, '0);
                it.reg_index = REG_TSTAMP;
                send_item(it, 1'b0, '0);
            end

            for (n = 0; n < ((phase == 2) ? 280 : 400); n++) begin
                it.write_data = $urandom;
                it.write_protected = ($urandom_range(0, 9) == 0);
                it.reg_index = 3'($urandom_range(0, 7));
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    it.kind = KIND_SLOW;
                end else if (pick < 60) begin
                    it.kind = KIND_HZ;
                end else if (pick < 82) begin
                    it.kind = KIND_READ;
                    if ($urandom_range(0, 2) == 0) it.reg_index = REG_STATUS;
                end else begin
                    it.kind = KIND_WRITE;
                    shape = $urandom_range(0, 9);
                    if (shape < 4) begin
                        it.reg_index = REG_MODE;
                        // Mostly a short prescaler so rollovers are frequent.
                        if ($urandom_range(0, 7) != 0) begin
                            wd = $urandom & 32'h0127_0000;
                            if ($urandom_range(0, 7) == 0) wd[MR_DIS_BIT] = 1'b1;
                            wd[15:0] = 16'($urandom_range(1, 4));
                            it.write_data = wd;
                        end
                    end else if (shape < 6) begin
                        it.reg_index = REG_ALARM;
                        if ($urandom_range(0, 3) != 0) begin
                            it.write_data = tm_count + $urandom_range(0, 12);
                        end
                    end else if (shape < 8) begin
                        it.reg_index = REG_MODULO;
                        if ($urandom_range(0, 3) != 0) begin
                            it.write_data[2:0] = 3'($urandom_range(0, 2));
                        end
                    end
                end
                send_item(it, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        while (timer_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items and %0d checked results under three idling patterns.",
                 n_items, n_checked);
        $display("Prescaler rollovers %0d, alarm matches %0d, boundary captures %0d.",
                 n_rollovers, n_alarm_hits, n_captures);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
